/* sv/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// Shared widths and the command and status groups that pass between the
// boxcar smoother controller and its datapath.
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int SAMPLE_W = 32;
  localparam int HW_W     = 6;

  typedef struct packed {
    logic accept;
    logic rd_win;
    logic sub;
    logic div_start;
    logic emit_mean;
    logic tail_next;
    logic plan_pt;
    logic rd_pt;
    logic emit_pt;
    logic emit_raw;
    logic clear;
  } bms_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic cnt_ge;
    logic last;
    logic need_remove;
    logic div_busy;
    logic out_free;
    logic tail_more;
    logic pt_final;
  } bms_sts_t;

endpackage

/* sv/bms_if.sv */
// ----------------------------------------------------------------------------
// bms_if
// Valid/ready channels for incoming samples and outgoing smoothed results.
// ----------------------------------------------------------------------------
interface bms_in_if;
  import bms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface bms_out_if;
  import bms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic                       applied;
  logic                       last_out;

  modport source (output valid, smoothed, applied, last_out, input ready);
  modport sink   (input valid, smoothed, applied, last_out, output ready);
endinterface

/* sv/bms_div.sv */
// ----------------------------------------------------------------------------
// bms_div
// Restoring divider, one quotient bit per cycle. Signed window sum over an
// unsigned window count, truncated toward zero.
// ----------------------------------------------------------------------------
module bms_div #(
  parameter int SUM_W = 39,
  parameter int CNT_W = 7
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUM_W-1:0]             dividend_i,
  input  logic        [CNT_W-1:0]             divisor_i,
  output logic                                busy_o,
  output logic signed [bms_pkg::SAMPLE_W-1:0] quot_o
);
  import bms_pkg::*;

  localparam int IW = $clog2(SUM_W + 1);

  logic              busy_q;
  logic [IW-1:0]     iter_q;
  logic              neg_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  div_q;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;
  logic [CNT_W-1:0]  rem_d;
  logic [SAMPLE_W-1:0] qlo;

  assign mag   = dividend_i[SUM_W-1] ? SUM_W'(~dividend_i + 1'b1) : SUM_W'(dividend_i);
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});
  assign rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign qlo   = quo_q[SAMPLE_W-1:0];

  assign busy_o = busy_q;
  assign quot_o = neg_q ? SAMPLE_W'(~qlo + 1'b1) : qlo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      iter_q <= IW'(SUM_W);
    end else if (busy_q) begin
      iter_q <= iter_q - 1'b1;
      if (iter_q == IW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

endmodule

/* sv/bms_dp.sv */
// ----------------------------------------------------------------------------
// bms_dp
// Smoother datapath: circular sample store, running window sum and count,
// divider, tail and passthrough index, result register.
// ----------------------------------------------------------------------------
module bms_dp #(
  parameter int MAX_HALF = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bms_pkg::HW_W-1:0]            half_width_i,
  input  logic signed [bms_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  input  bms_pkg::bms_cmd_t                   cmd_i,
  output bms_pkg::bms_sts_t                   sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bms_pkg::SAMPLE_W-1:0] smoothed_o,
  output logic                                applied_o,
  output logic                                last_out_o
);
  import bms_pkg::*;

  localparam int KW        = $clog2(MAX_HALF + 1);
  localparam int CNT_W     = $clog2(2 * MAX_HALF + 3);
  localparam int MEM_DEPTH = 2 * MAX_HALF + 2;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CNT_MAX   = 2 * MAX_HALF + 1;
  localparam int SUM_W     = SAMPLE_W + $clog2(2 * MAX_HALF + 1);

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];

  logic [AW-1:0]              wptr_q, wptr_d;
  logic [CNT_W-1:0]           cnt_q, win_q;
  logic [KW-1:0]              k_q, r_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] x_q, rdata_q;
  logic                       out_valid_q;

  logic [KW-1:0]              k_cfg, k_acc;
  logic [CNT_W-1:0]           off, target;
  logic [AW:0]                adiff;
  logic [AW-1:0]              raddr;
  logic                       rd_en;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] quot;

  always_comb begin
    if (int'(half_width_i) > MAX_HALF) begin
      k_cfg = KW'(MAX_HALF);
    end else begin
      k_cfg = KW'(half_width_i);
    end
  end

  assign k_acc  = (cnt_q == '0) ? k_cfg : k_q;
  assign wptr_d = (wptr_q == AW'(MEM_DEPTH - 1)) ? '0 : wptr_q + 1'b1;

  // offset back from the newest sample
  assign off    = cmd_i.rd_win ? win_q - 1'b1 : CNT_W'(r_q) - 1'b1;
  assign adiff  = {1'b0, wptr_q} - {1'b0, AW'(off)};
  assign raddr  = adiff[AW] ? AW'(adiff[AW-1:0] + AW'(MEM_DEPTH)) : adiff[AW-1:0];
  assign rd_en  = cmd_i.rd_win | cmd_i.rd_pt;

  assign target = CNT_W'({k_q, 1'b1}) - CNT_W'(r_q);

  always_comb begin
    sts_o.k_zero      = (k_q == '0);
    sts_o.cnt_ge      = (cnt_q > CNT_W'(k_q));
    sts_o.last        = last_q;
    sts_o.need_remove = (win_q > target);
    sts_o.div_busy    = div_busy;
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.tail_more   = (r_q != k_q);
    sts_o.pt_final    = (r_q == KW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[wptr_d] <= sample_i;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      cnt_q  <= '0;
      win_q  <= '0;
      k_q    <= '0;
      r_q    <= '0;
      sum_q  <= '0;
      last_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        wptr_q <= wptr_d;
        k_q    <= k_acc;
        last_q <= last_i;
        r_q    <= '0;
        if (cnt_q != CNT_W'(CNT_MAX)) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (k_acc != '0) begin
          sum_q <= sum_q + SUM_W'(sample_i);
          win_q <= win_q + 1'b1;
        end
      end
      if (cmd_i.sub && sts_o.need_remove) begin
        sum_q <= sum_q - SUM_W'(rdata_q);
        win_q <= win_q - 1'b1;
      end
      if (cmd_i.clear) begin
        r_q <= '0;
      end else if (cmd_i.tail_next) begin
        r_q <= r_q + 1'b1;
      end else if (cmd_i.plan_pt) begin
        r_q <= KW'(cnt_q);
      end else if (cmd_i.emit_pt) begin
        r_q <= r_q - 1'b1;
      end
      if (cmd_i.clear) begin
        cnt_q <= '0;
        win_q <= '0;
        sum_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
  end

  bms_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (win_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_mean || cmd_i.emit_pt || cmd_i.emit_raw) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_mean) begin
      smoothed_o <= quot;
      applied_o  <= 1'b1;
      last_out_o <= last_q && (r_q == k_q);
    end else if (cmd_i.emit_pt) begin
      smoothed_o <= rdata_q;
      applied_o  <= 1'b0;
      last_out_o <= (r_q == KW'(1));
    end else if (cmd_i.emit_raw) begin
      smoothed_o <= x_q;
      applied_o  <= 1'b0;
      last_out_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/bms_ctrl.sv */
// ----------------------------------------------------------------------------
// bms_ctrl
// Sequencer for the smoother: takes one sample, plans its results, then walks
// window update, divide and emit per mean, read and emit per passthrough.
// ----------------------------------------------------------------------------
module bms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bms_pkg::bms_sts_t sts_i,
  output bms_pkg::bms_cmd_t cmd_o
);
  import bms_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PLAN    = 4'd1;
  localparam logic [3:0] S_RD      = 4'd2;
  localparam logic [3:0] S_SUB     = 4'd3;
  localparam logic [3:0] S_DSTART  = 4'd4;
  localparam logic [3:0] S_DWAIT   = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_PT_RD   = 4'd7;
  localparam logic [3:0] S_PT_EMIT = 4'd8;
  localparam logic [3:0] S_RAW     = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PLAN;
        end
      end
      S_PLAN: begin
        if (sts_i.k_zero) begin
          state_d = S_RAW;
        end else if (sts_i.cnt_ge) begin
          state_d = S_RD;
        end else if (sts_i.last) begin
          cmd_o.plan_pt = 1'b1;
          state_d       = S_PT_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_win = 1'b1;
        state_d      = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_mean = 1'b1;
          if (sts_i.last && sts_i.tail_more) begin
            cmd_o.tail_next = 1'b1;
            state_d         = S_RD;
          end else begin
            cmd_o.clear = sts_i.last;
            state_d     = S_IDLE;
          end
        end
      end
      S_PT_RD: begin
        cmd_o.rd_pt = 1'b1;
        state_d     = S_PT_EMIT;
      end
      S_PT_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          if (sts_i.pt_final) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            state_d = S_PT_RD;
          end
        end
      end
      S_RAW: begin
        if (sts_i.out_free) begin
          cmd_o.emit_raw = 1'b1;
          cmd_o.clear    = sts_i.last;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/boxcar_mean_smoother_core.sv */
// ----------------------------------------------------------------------------
// boxcar_mean_smoother_core
// Boxcar mean over a clipped window of +/- k samples per spectrum.
//
//   channel  dir  beat                              handshake
//   samp_i   in   sample, last                      valid/ready
//   res_o    out  smoothed, applied, last_out       valid/ready
//   apb      in   half_width at byte address 0      psel/penable, pready tied
//
// A sample is taken and then planned; each mean that it releases waits on
// the serial divider, which yields one quotient bit per cycle. The last
// sample releases k + 1 means when more than k samples have come; else the
// stored samples pass through, each beat a store read and then a result.
// Reset clears the counters, sum and result valid; the store needs no clear.
// A stalled result register holds the sequencer; no sample is taken meanwhile.
// ----------------------------------------------------------------------------
module boxcar_mean_smoother_core #(
  parameter int MAX_HALF = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bms_in_if.sink      samp_i,
  bms_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bms_pkg::*;

  localparam int         DATA_W         = 32;
  localparam logic       IDX_HALF_WIDTH = 1'b0;
  localparam logic [HW_W-1:0] HALF_WIDTH_RST = HW_W'(1);

  logic [HW_W-1:0] half_width_q;
  logic            cfg_wr;
  bms_cmd_t        cmd;
  bms_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == IDX_HALF_WIDTH);
  assign prdata = (paddr[2] == IDX_HALF_WIDTH) ? DATA_W'(half_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RST;
    end else if (cfg_wr) begin
      half_width_q <= pwdata[HW_W-1:0];
    end
  end

  bms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (samp_i.valid),
    .in_ready_o (samp_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bms_dp #(
    .MAX_HALF (MAX_HALF)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .half_width_i (half_width_q),
    .sample_i     (samp_i.sample),
    .last_i       (samp_i.last),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .smoothed_o   (res_o.smoothed),
    .applied_o    (res_o.applied),
    .last_out_o   (res_o.last_out)
  );

endmodule
